// ----- rtl/ppms_pkg.sv -----
// Package for the pick and place motion sequencer: types, codes and coordinate tables.
`timescale 1ns / 1ps

package ppms_pkg;

  // Default sizes
  localparam int BoardCellsDefault = 9;
  localparam int PieceSlotsDefault = 10;
  localparam int TimerBitsDefault  = 16;

  // Field widths
  localparam int CoordBits = 18;
  localparam int XyBits    = 2 * CoordBits;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 16;

  // Configuration register indexes
  localparam logic [CfgIdxBits-1:0] CFG_ROTATE   = 3'd0;
  localparam logic [CfgIdxBits-1:0] CFG_CHEAT    = 3'd1;
  localparam logic [CfgIdxBits-1:0] CFG_DWELL    = 3'd2;
  localparam logic [CfgIdxBits-1:0] CFG_AXIS     = 3'd3;
  localparam logic [CfgIdxBits-1:0] CFG_SPEED    = 3'd4;
  localparam logic [CfgIdxBits-1:0] CFG_ACCEL    = 3'd5;
  localparam logic [CfgIdxBits-1:0] CFG_ABSOLUTE = 3'd6;

  // Configuration reset values
  localparam logic [15:0] DWELL_RESET = 16'd700;
  localparam logic [15:0] AXIS_RESET  = 16'd1500;
  localparam logic [15:0] SPEED_RESET = 16'd300;
  localparam logic [7:0]  ACCEL_RESET = 8'd0;

  // Input kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  // Actuator and motor codes
  localparam logic [1:0] SERVO_NONE  = 2'd0;
  localparam logic [1:0] SERVO_LOWER = 2'd1;
  localparam logic [1:0] SERVO_RAISE = 2'd2;
  localparam logic [1:0] MAG_NONE    = 2'd0;
  localparam logic [1:0] MAG_ON      = 2'd1;
  localparam logic [1:0] MAG_OFF     = 2'd2;
  localparam logic [1:0] AXIS_X      = 2'd1;
  localparam logic [1:0] AXIS_Y      = 2'd2;

  // Placement sequencer steps
  typedef enum logic [4:0] {
    P_IDLE, P_MOVE_PICK, P_WAIT_ARR1, P_LOWER1, P_WAIT_LOWER1, P_MAG_ON,
    P_WAIT_MAG_ON, P_RAISE1, P_WAIT_RAISE1, P_MOVE_DROP, P_WAIT_ARR2, P_LOWER2,
    P_WAIT_LOWER2, P_MAG_OFF, P_WAIT_MAG_OFF, P_RAISE2, P_WAIT_RAISE2,
    P_MOVE_ZERO, P_WAIT_ZERO, P_DONE
  } place_step_e;

  // Two-axis move steps
  typedef enum logic [2:0] {
    M_IDLE, M_SET_X, M_WAIT_X, M_SET_Y, M_WAIT_Y, M_DONE
  } motion_step_e;

  // Input transaction
  typedef struct packed {
    logic       kind;
    logic [3:0] piece_slot;
    logic [3:0] board_cell;
  } ppms_in_t;

  // Result transaction
  typedef struct packed {
    logic                 accepted;
    logic                 motor_cmd_valid;
    logic [1:0]           motor_axis;
    logic                 motor_direction;
    logic [CoordBits-1:0] motor_target;
    logic [15:0]          motor_speed;
    logic [7:0]           motor_accel;
    logic                 motor_absolute;
    logic [1:0]           servo_cmd;
    logic [1:0]           magnet_cmd;
    logic                 place_busy;
    logic                 motion_busy;
  } ppms_out_t;

  // Pack a coordinate pair: x in the low half, y in the high half
  function automatic logic [XyBits-1:0] xy(input int unsigned x, input int unsigned y);
    logic [31:0] xv;
    logic [31:0] yv;
    xv = x;
    yv = y;
    return {yv[CoordBits-1:0], xv[CoordBits-1:0]};
  endfunction

  // Normal board layout; unlisted cells read (0,0)
  function automatic logic [XyBits-1:0] board_xy(input logic [3:0] i);
    logic [XyBits-1:0] r;
    case (i)
      4'd0:    r = xy(4500, 9500);
      4'd1:    r = xy(7200, 7200);
      4'd2:    r = xy(9500, 5000);
      4'd3:    r = xy(7000, 12000);
      4'd4:    r = xy(9500, 9500);
      4'd5:    r = xy(142000, 7000);
      4'd6:    r = xy(9300, 14300);
      4'd7:    r = xy(11800, 9300);
      4'd8:    r = xy(14100, 9600);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Rotated board layout
  function automatic logic [XyBits-1:0] rotated_xy(input logic [3:0] i);
    logic [XyBits-1:0] r;
    case (i)
      4'd0:    r = xy(8000, 8000);
      4'd1:    r = xy(8000, 11500);
      4'd2:    r = xy(11500, 8000);
      4'd3:    r = xy(8000, 15000);
      4'd4:    r = xy(11500, 11500);
      4'd5:    r = xy(15000, 8000);
      4'd6:    r = xy(15000, 10000);
      4'd7:    r = xy(10000, 15000);
      4'd8:    r = xy(15000, 15000);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Piece slot positions
  function automatic logic [XyBits-1:0] slot_xy(input logic [3:0] i);
    logic [XyBits-1:0] r;
    case (i)
      4'd0:    r = xy(0, 13500);
      4'd1:    r = xy(2000, 15500);
      4'd2:    r = xy(4000, 17500);
      4'd3:    r = xy(6000, 19500);
      4'd4:    r = xy(8000, 21500);
      4'd5:    r = xy(13500, 0);
      4'd6:    r = xy(15500, 2000);
      4'd7:    r = xy(17500, 4000);
      4'd8:    r = xy(19500, 6000);
      4'd9:    r = xy(21500, 8000);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/pick_place_motion_sequencer.sv -----
// A result appears on the output register in the cycle after its transaction.
// Throughput: one transaction per cycle; the single result register sets the pace
// and the input takes a new transaction whenever that register is empty or drained.
// Reset (asynchronous, active low): both sequencers idle, timers and coordinates
// cleared, configuration at its documented defaults, no result pending.
`timescale 1ns / 1ps

module pick_place_motion_sequencer
  import ppms_pkg::*;
#(
  parameter int BOARD_CELLS = BoardCellsDefault,
  parameter int PIECE_SLOTS = PieceSlotsDefault,
  parameter int TIMER_BITS  = TimerBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  // Input channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  ppms_in_t               in_data_i,
  // Result channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output ppms_out_t              out_data_o
);

  localparam int CmpBits = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  // Configuration registers
  logic        rotate_q, cheat_q, absolute_q;
  logic [15:0] dwell_q, axis_wait_q, speed_q;
  logic [7:0]  accel_q;

  // Sequencer state
  place_step_e           pstep_q, pstep_d;
  motion_step_e          mstep_q, mstep_d, mstep_mid;
  logic [TIMER_BITS-1:0] ptimer_q, ptimer_d, mtimer_q, mtimer_d;
  logic [XyBits-1:0]     pick_q, pick_d, drop_q, drop_d, target_q, target_d;

  // Result register
  logic      out_valid_q;
  ppms_out_t out_data_q, res;

  logic in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_fire     = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Saturating tick count
  function automatic logic [TIMER_BITS-1:0] tick_inc(input logic [TIMER_BITS-1:0] t);
    return (t == '1) ? t : t + 1'b1;
  endfunction

  // Wait is over once the count reaches the limit
  function automatic logic wait_done(input logic [TIMER_BITS-1:0] t,
                                     input logic [15:0] lim);
    return CmpBits'(t) >= CmpBits'(lim);
  endfunction

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotate_q    <= 1'b0;
      cheat_q     <= 1'b0;
      dwell_q     <= DWELL_RESET;
      axis_wait_q <= AXIS_RESET;
      speed_q     <= SPEED_RESET;
      accel_q     <= ACCEL_RESET;
      absolute_q  <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ROTATE:   rotate_q    <= cfg_data_i[0];
        CFG_CHEAT:    cheat_q     <= cfg_data_i[0];
        CFG_DWELL:    dwell_q     <= cfg_data_i;
        CFG_AXIS:     axis_wait_q <= cfg_data_i;
        CFG_SPEED:    speed_q     <= cfg_data_i;
        CFG_ACCEL:    accel_q     <= cfg_data_i[7:0];
        CFG_ABSOLUTE: absolute_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Next state and result for one transaction
  always_comb begin
    logic busy, ok, mbusy;
    pstep_d   = pstep_q;
    mstep_d   = mstep_q;
    ptimer_d  = ptimer_q;
    mtimer_d  = mtimer_q;
    pick_d    = pick_q;
    drop_d    = drop_q;
    target_d  = target_q;
    res       = '0;
    busy      = (pstep_q != P_IDLE) || (mstep_q != M_IDLE);
    mbusy     = (mstep_q != M_IDLE);
    ok        = ({1'b0, in_data_i.piece_slot} < 5'(PIECE_SLOTS)) &&
                ({1'b0, in_data_i.board_cell} < 5'(BOARD_CELLS));
    if (cheat_q && ({1'b0, in_data_i.piece_slot} >= 5'(BOARD_CELLS))) begin
      ok = 1'b0;
    end

    if (in_data_i.kind == KIND_START) begin
      // Start: latch coordinates when free and in range
      if (!busy && ok) begin
        if (cheat_q) begin
          pick_d = board_xy(in_data_i.piece_slot);
          drop_d = board_xy(in_data_i.board_cell);
        end else begin
          pick_d = slot_xy(in_data_i.piece_slot);
          drop_d = rotate_q ? rotated_xy(in_data_i.board_cell)
                            : board_xy(in_data_i.board_cell);
        end
        pstep_d      = P_MOVE_PICK;
        ptimer_d     = '0;
        res.accepted = 1'b1;
      end
      mstep_mid = mstep_q;
    end else begin
      // Placement step runs first
      case (pstep_q)
        P_IDLE: ;
        P_MOVE_PICK: begin
          target_d = pick_q; mstep_d = M_SET_X; mtimer_d = '0; pstep_d = P_WAIT_ARR1;
        end
        P_WAIT_ARR1: if (!mbusy) pstep_d = P_LOWER1;
        P_LOWER1: begin
          res.servo_cmd = SERVO_LOWER; ptimer_d = '0; pstep_d = P_WAIT_LOWER1;
        end
        P_WAIT_LOWER1: begin
          ptimer_d = tick_inc(ptimer_q);
          if (wait_done(ptimer_d, dwell_q)) pstep_d = P_MAG_ON;
        end
        P_MAG_ON: begin
          res.magnet_cmd = MAG_ON; ptimer_d = '0; pstep_d = P_WAIT_MAG_ON;
        end
        P_WAIT_MAG_ON: begin
          ptimer_d = tick_inc(ptimer_q);
          if (wait_done(ptimer_d, dwell_q)) pstep_d = P_RAISE1;
        end
        P_RAISE1: begin
          res.servo_cmd = SERVO_RAISE; ptimer_d = '0; pstep_d = P_WAIT_RAISE1;
        end
        P_WAIT_RAISE1: begin
          ptimer_d = tick_inc(ptimer_q);
          if (wait_done(ptimer_d, dwell_q)) pstep_d = P_MOVE_DROP;
        end
        P_MOVE_DROP: begin
          target_d = drop_q; mstep_d = M_SET_X; mtimer_d = '0; pstep_d = P_WAIT_ARR2;
        end
        P_WAIT_ARR2: if (!mbusy) pstep_d = P_LOWER2;
        P_LOWER2: begin
          res.servo_cmd = SERVO_LOWER; ptimer_d = '0; pstep_d = P_WAIT_LOWER2;
        end
        P_WAIT_LOWER2: begin
          ptimer_d = tick_inc(ptimer_q);
          if (wait_done(ptimer_d, dwell_q)) pstep_d = P_MAG_OFF;
        end
        P_MAG_OFF: begin
          res.magnet_cmd = MAG_OFF; ptimer_d = '0; pstep_d = P_WAIT_MAG_OFF;
        end
        P_WAIT_MAG_OFF: begin
          ptimer_d = tick_inc(ptimer_q);
          if (wait_done(ptimer_d, dwell_q)) pstep_d = P_RAISE2;
        end
        P_RAISE2: begin
          res.servo_cmd = SERVO_RAISE; ptimer_d = '0; pstep_d = P_WAIT_RAISE2;
        end
        P_WAIT_RAISE2: begin
          ptimer_d = tick_inc(ptimer_q);
          if (wait_done(ptimer_d, dwell_q)) pstep_d = P_MOVE_ZERO;
        end
        P_MOVE_ZERO: begin
          target_d = '0; mstep_d = M_SET_X; mtimer_d = '0; pstep_d = P_WAIT_ZERO;
        end
        P_WAIT_ZERO: if (!mbusy) pstep_d = P_DONE;
        default: pstep_d = P_IDLE;
      endcase

      // Motion step sees what the placement step left
      mstep_mid = mstep_d;
      case (mstep_mid)
        M_IDLE: ;
        M_SET_X: begin
          res.motor_cmd_valid = 1'b1;
          res.motor_axis      = AXIS_X;
          res.motor_direction = 1'b0;
          res.motor_target    = target_d[CoordBits-1:0];
          res.motor_speed     = speed_q;
          res.motor_accel     = accel_q;
          res.motor_absolute  = absolute_q;
          mtimer_d            = '0;
          mstep_d             = M_WAIT_X;
        end
        M_WAIT_X: begin
          mtimer_d = tick_inc(mtimer_d);
          if (wait_done(mtimer_d, axis_wait_q)) mstep_d = M_SET_Y;
        end
        M_SET_Y: begin
          res.motor_cmd_valid = 1'b1;
          res.motor_axis      = AXIS_Y;
          res.motor_direction = 1'b1;
          res.motor_target    = target_d[XyBits-1:CoordBits];
          res.motor_speed     = speed_q;
          res.motor_accel     = accel_q;
          res.motor_absolute  = absolute_q;
          mtimer_d            = '0;
          mstep_d             = M_WAIT_Y;
        end
        M_WAIT_Y: begin
          mtimer_d = tick_inc(mtimer_d);
          if (wait_done(mtimer_d, axis_wait_q)) mstep_d = M_DONE;
        end
        default: mstep_d = M_IDLE;
      endcase
    end

    res.place_busy  = (pstep_d != P_IDLE);
    res.motion_busy = (mstep_d != M_IDLE);
  end

  // Sequencer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pstep_q  <= P_IDLE;
      mstep_q  <= M_IDLE;
      ptimer_q <= '0;
      mtimer_q <= '0;
      pick_q   <= '0;
      drop_q   <= '0;
      target_q <= '0;
    end else if (in_fire) begin
      pstep_q  <= pstep_d;
      mstep_q  <= mstep_d;
      ptimer_q <= ptimer_d;
      mtimer_q <= mtimer_d;
      pick_q   <= pick_d;
      drop_q   <= drop_d;
      target_q <= target_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= res;
    end
  end

`ifndef NO_ASSERTIONS
  // A motor command always leaves the move in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.motor_cmd_valid |-> out_data_o.motion_busy)
    else $error("motor command without move in progress");

  // An accepted start always leaves the placement busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.accepted |-> out_data_o.place_busy)
    else $error("accepted start without placement busy");

  // Actuator commands only come from a running placement
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.servo_cmd != SERVO_NONE ||
                    out_data_o.magnet_cmd != MAG_NONE) |-> out_data_o.place_busy)
    else $error("actuator command while placement idle");

  // An accepted transaction always shows up on the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted transaction produced no result");
`endif

endmodule
